// ===== design/lswc_pkg.sv =====
// ----------------------------------------------------------------------------
// lswc_pkg
// Shared constants for the line segment window clip: register map and
// stream payload widths.
// ----------------------------------------------------------------------------
package lswc_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_WEST  = 2'd0;
    localparam logic [1:0] REG_EAST  = 2'd1;
    localparam logic [1:0] REG_SOUTH = 2'd2;
    localparam logic [1:0] REG_NORTH = 2'd3;

    // register reset values
    localparam logic [31:0] WEST_RST  = 32'h0000_0000;
    localparam logic [31:0] EAST_RST  = 32'h7FFF_FFFF;
    localparam logic [31:0] SOUTH_RST = 32'h0000_0000;
    localparam logic [31:0] NORTH_RST = 32'h7FFF_FFFF;

    // field and bus widths
    localparam int FIELD_W  = 32;
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 136;
    localparam int ADDR_W   = 4;

endpackage

// ===== design/lswc_step.sv =====
// ----------------------------------------------------------------------------
// lswc_step
// One clip step: compare a coordinate against an edge, interpolate the other
// coordinate along the line (full product, restoring divide one quotient bit
// per stage, saturating add) and clamp. Tuple order in and out: c, o, pc, po,
// hit (c lowest).
// ----------------------------------------------------------------------------
module lswc_step #(
    parameter int W = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           below,
    input  logic [W-1:0]   edge_val,
    input  logic           in_valid,
    input  logic [4*W:0]   in_data,
    output logic           out_valid,
    output logic [4*W:0]   out_data
);

    localparam int TW = 4*W + 1;
    localparam int DN = W + 1;

    // ---------------- stage A: compare and differences ----------------
    logic signed [W-1:0] c_in, o_in, pc_in, po_in, edge_s;
    logic signed [W:0]   num, fac, den;
    logic                beyond;

    assign c_in   = $signed(in_data[W-1:0]);
    assign o_in   = $signed(in_data[2*W-1:W]);
    assign pc_in  = $signed(in_data[3*W-1:2*W]);
    assign po_in  = $signed(in_data[4*W-1:3*W]);
    assign edge_s = $signed(edge_val);

    always_comb begin
        num    = {edge_s[W-1], edge_s} - {c_in[W-1], c_in};
        fac    = {po_in[W-1], po_in} - {o_in[W-1], o_in};
        den    = {pc_in[W-1], pc_in} - {c_in[W-1], c_in};
        beyond = below ? (c_in < edge_s) : (c_in > edge_s);
    end

    logic            a_v_reg;
    logic [TW-1:0]   a_tup_reg;
    logic [W:0]      a_num_reg, a_fac_reg, a_den_reg;
    logic            a_neg_reg, a_hit_reg, a_int_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_tup_reg <= in_data;
            a_num_reg <= num[W] ? (~num + 1'b1) : num;
            a_fac_reg <= fac[W] ? (~fac + 1'b1) : fac;
            a_den_reg <= den[W] ? (~den + 1'b1) : den;
            a_neg_reg <= num[W] ^ fac[W] ^ den[W];
            a_hit_reg <= beyond;
            a_int_reg <= beyond && (pc_in != c_in);
        end
    end

    // ---------------- stage B: magnitude product ----------------
    logic            b_v_reg;
    logic [TW-1:0]   b_tup_reg;
    logic [2*W+1:0]  b_prod_reg;
    logic [W:0]      b_den_reg;
    logic            b_neg_reg, b_hit_reg, b_int_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (en) begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_tup_reg  <= a_tup_reg;
            b_prod_reg <= a_num_reg * a_fac_reg;
            b_den_reg  <= a_den_reg;
            b_neg_reg  <= a_neg_reg;
            b_hit_reg  <= a_hit_reg;
            b_int_reg  <= a_int_reg;
        end
    end

    // ---------------- divider: prep stage then one bit per stage ----------------
    logic            d_v_reg   [0:DN];
    logic [TW-1:0]   d_tup_reg [0:DN];
    logic [W:0]      d_rem_reg [0:DN];
    logic [W:0]      d_low_reg [0:DN];
    logic [W:0]      d_q_reg   [0:DN];
    logic [W:0]      d_den_reg [0:DN];
    logic            d_neg_reg [0:DN];
    logic            d_hit_reg [0:DN];
    logic            d_int_reg [0:DN];
    logic            d_ovf_reg [0:DN];

    // prep: high half becomes the partial remainder; quotient too wide if
    // it already reaches the divisor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg[0] <= 1'b0;
        end else if (en) begin
            d_v_reg[0] <= b_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_tup_reg[0] <= b_tup_reg;
            d_rem_reg[0] <= b_prod_reg[2*W+1:W+1];
            d_low_reg[0] <= b_prod_reg[W:0];
            d_q_reg[0]   <= '0;
            d_den_reg[0] <= b_den_reg;
            d_neg_reg[0] <= b_neg_reg;
            d_hit_reg[0] <= b_hit_reg;
            d_int_reg[0] <= b_int_reg;
            d_ovf_reg[0] <= (b_prod_reg[2*W+1:W+1] >= b_den_reg);
        end
    end

    genvar k;
    generate
        for (k = 1; k <= DN; k++) begin : g_div
            logic [W+1:0] trial;
            logic         ge;
            logic [W+1:0] diff;

            always_comb begin
                trial = {d_rem_reg[k-1], d_low_reg[k-1][W]};
                ge    = (trial >= {1'b0, d_den_reg[k-1]});
                diff  = trial - {1'b0, d_den_reg[k-1]};
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    d_v_reg[k] <= 1'b0;
                end else if (en) begin
                    d_v_reg[k] <= d_v_reg[k-1];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    d_tup_reg[k] <= d_tup_reg[k-1];
                    d_rem_reg[k] <= ge ? diff[W:0] : trial[W:0];
                    d_low_reg[k] <= {d_low_reg[k-1][W-1:0], 1'b0};
                    d_q_reg[k]   <= {d_q_reg[k-1][W-1:0], ge};
                    d_den_reg[k] <= d_den_reg[k-1];
                    d_neg_reg[k] <= d_neg_reg[k-1];
                    d_hit_reg[k] <= d_hit_reg[k-1];
                    d_int_reg[k] <= d_int_reg[k-1];
                    d_ovf_reg[k] <= d_ovf_reg[k-1];
                end
            end
        end
    endgenerate

    // ---------------- final: saturating add and clamp ----------------
    logic [TW-1:0]  f_tup;
    logic [W-1:0]   f_o;
    logic [W+2:0]   o_ext, q_ext, sum;
    logic [W-1:0]   o_new;
    logic [W-1:0]   c_new;
    logic [TW-1:0]  out_next;
    logic [TW-1:0]  out_reg;
    logic           v_reg;

    always_comb begin
        f_tup = d_tup_reg[DN];
        f_o   = f_tup[2*W-1:W];
        o_ext = {{3{f_o[W-1]}}, f_o};
        q_ext = {2'b00, d_q_reg[DN]};
        sum   = d_neg_reg[DN] ? (o_ext - q_ext) : (o_ext + q_ext);
        o_new = f_o;
        if (d_int_reg[DN]) begin
            if (d_ovf_reg[DN]) begin
                o_new = d_neg_reg[DN] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else if (sum[W+2:W-1] == '0 || sum[W+2:W-1] == '1) begin
                o_new = sum[W-1:0];
            end else begin
                o_new = sum[W+2] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
        end
        c_new    = d_hit_reg[DN] ? edge_val : f_tup[W-1:0];
        out_next = {f_tup[4*W] | d_hit_reg[DN], f_tup[4*W-1:2*W], o_new, c_new};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= d_v_reg[DN];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = out_reg;

endmodule

// ===== design/line_segment_window_clip.sv =====
// Throughput: one segment per cycle unless m_tready stalls the output; each of
// the eight clip steps is a chain of compare, multiply, one-bit-per-stage divide
// and saturate stages.
// A stall on m_tready holds the whole pipeline; s_tready follows it.
// Reset (aresetn, synchronous, low) clears all valid bits and loads the edges
// with west/south 0 and east/north 0x7FFFFFFF.
// ----------------------------------------------------------------------------
// line_segment_window_clip
// Clips a segment against a window held in four APB registers, eight fixed
// steps in a row, and streams out the clipped endpoints and a clip flag.
// ----------------------------------------------------------------------------
module line_segment_window_clip #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lswc_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // input segments
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lswc_pkg::S_DATA_W-1:0]   s_tdata,  // first_x, first_y, second_x,
                                                      // second_y
    // clipped segments
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lswc_pkg::M_DATA_W-1:0]   m_tdata   // clipped_first_x, clipped_first_y,
                                                      // clipped_second_x, clipped_second_y,
                                                      // was_clipped, zero fill
);

    localparam int W  = COORD_WIDTH;
    localparam int TW = 4*W + 1;
    localparam int FW = lswc_pkg::FIELD_W;

    // ---------------- configuration registers ----------------
    logic [31:0] west_reg, east_reg, south_reg, north_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            west_reg  <= lswc_pkg::WEST_RST;
            east_reg  <= lswc_pkg::EAST_RST;
            south_reg <= lswc_pkg::SOUTH_RST;
            north_reg <= lswc_pkg::NORTH_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                lswc_pkg::REG_WEST:  west_reg  <= pwdata;
                lswc_pkg::REG_EAST:  east_reg  <= pwdata;
                lswc_pkg::REG_SOUTH: south_reg <= pwdata;
                lswc_pkg::REG_NORTH: north_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lswc_pkg::REG_WEST:  prdata = west_reg;
            lswc_pkg::REG_EAST:  prdata = east_reg;
            lswc_pkg::REG_SOUTH: prdata = south_reg;
            lswc_pkg::REG_NORTH: prdata = north_reg;
            default:             prdata = '0;
        endcase
    end

    logic [W-1:0] edge_w, edge_e, edge_s, edge_n;
    assign edge_w = W'(west_reg);
    assign edge_e = W'(east_reg);
    assign edge_s = W'(south_reg);
    assign edge_n = W'(north_reg);

    // ---------------- step chain ----------------
    // canonical tuple between steps: x1, y1, x2, y2, hit (x1 lowest)
    logic          en;
    logic [TW-1:0] canon [0:8];
    logic          cval  [0:8];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign cval[0]  = s_tvalid;
    assign canon[0] = {1'b0, W'(s_tdata[4*FW-1:3*FW]), W'(s_tdata[3*FW-1:2*FW]),
                       W'(s_tdata[2*FW-1:FW]), W'(s_tdata[FW-1:0])};

    genvar i;
    generate
        for (i = 0; i < 8; i++) begin : g_step
            logic [TW-1:0] st_in, st_out;
            logic [W-1:0]  x1, y1, x2, y2;
            logic [W-1:0]  edge_sel;

            assign x1 = canon[i][W-1:0];
            assign y1 = canon[i][2*W-1:W];
            assign x2 = canon[i][3*W-1:2*W];
            assign y2 = canon[i][4*W-1:3*W];

            // step tuple is c, o, pc, po
            if (i / 2 == 0) begin : g_p0
                assign st_in = {canon[i][4*W], y2, x2, y1, x1};
                assign canon[i+1] = st_out;
            end else if (i / 2 == 1) begin : g_p1
                assign st_in = {canon[i][4*W], y1, x1, y2, x2};
                assign canon[i+1] = {st_out[4*W], st_out[2*W-1:0], st_out[4*W-1:2*W]};
            end else if (i / 2 == 2) begin : g_p2
                assign st_in = {canon[i][4*W], x2, y2, x1, y1};
                assign canon[i+1] = {st_out[4*W], st_out[3*W-1:2*W], st_out[4*W-1:3*W],
                                     st_out[W-1:0], st_out[2*W-1:W]};
            end else begin : g_p3
                assign st_in = {canon[i][4*W], x1, y1, x2, y2};
                assign canon[i+1] = {st_out[4*W], st_out[W-1:0], st_out[2*W-1:W],
                                     st_out[3*W-1:2*W], st_out[4*W-1:3*W]};
            end

            if (i < 4) begin : g_x
                assign edge_sel = (i % 2 == 0) ? edge_w : edge_e;
            end else begin : g_y
                assign edge_sel = (i % 2 == 0) ? edge_s : edge_n;
            end

            lswc_step #(.W(W)) u_step (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .below     ((i % 2) == 0),
                .edge_val  (edge_sel),
                .in_valid  (cval[i]),
                .in_data   (st_in),
                .out_valid (cval[i+1]),
                .out_data  (st_out)
            );
        end
    endgenerate

    // ---------------- result stream ----------------
    assign m_tvalid = cval[8];
    assign m_tdata  = {7'b0, canon[8][4*W],
                       FW'(canon[8][4*W-1:3*W]), FW'(canon[8][3*W-1:2*W]),
                       FW'(canon[8][2*W-1:W]), FW'(canon[8][W-1:0])};

endmodule
